FILE: rtl/gbmr_pkg.sv
// Package with the shared constants, types and codes of the grid bin mean and residual block.
package gbmr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int GRID_BINS_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int IDX_W = 12;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;
  localparam int OP_W  = 2;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Opcodes of an input item.
  localparam logic [OP_W-1:0] OP_ACC = 2'd0;
  localparam logic [OP_W-1:0] OP_RES = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  // Saturation limits.
  localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] WORD_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Kind of work queued for the back end.
  typedef enum logic [1:0] {
    KIND_ACC,
    KIND_RES,
    KIND_CLR
  } kind_t;

  // One queued command.
  typedef struct packed {
    kind_t                    kind;
    logic                     in_range;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_RES_RD,
    ST_RES_DIV,
    ST_RES_OUT
  } back_state_t;

endpackage

FILE: rtl/gbmr_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gbmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gbmr_div.sv
// Iterative unsigned divider that retires two quotient bits per cycle.
module gbmr_div #(
  parameter int DVD_W = 48,
  parameter int DIV_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEPS = (DVD_W + 1) / 2;
  localparam int Q_W   = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  logic             running;
  logic [CNT_W-1:0] step;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsor;
  logic [Q_W-1:0]   quo;

  logic [DIV_W:0]   r1;
  logic [DIV_W:0]   r1_sub;
  logic             ge1;
  logic [DIV_W-1:0] rem1;
  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   r2_sub;
  logic             ge2;
  logic [DIV_W-1:0] rem2;

  // Two restoring steps: shift in a dividend bit, subtract when it fits.
  always_comb begin
    r1     = {rem, quo[Q_W-1]};
    ge1    = (r1 >= {1'b0, dsor});
    r1_sub = ge1 ? (r1 - {1'b0, dsor}) : r1;
    rem1   = r1_sub[DIV_W-1:0];
    r2     = {rem1, quo[Q_W-2]};
    ge2    = (r2 >= {1'b0, dsor});
    r2_sub = ge2 ? (r2 - {1'b0, dsor}) : r2;
    rem2   = r2_sub[DIV_W-1:0];
  end

  assign quotient = quo[DVD_W-1:0];

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && (step == LAST_STEP);
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == LAST_STEP) begin
          running <= 1'b0;
        end
        step <= step + 1'b1;
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsor <= divisor;
      quo  <= Q_W'(dividend);
    end else if (running) begin
      rem <= rem2;
      quo <= {quo[Q_W-3:0], ge1, ge2};
    end
  end

endmodule

FILE: rtl/gbmr_front.sv
// Front end: accepts items, classifies them and queues the work for the back end.
module gbmr_front #(
  parameter int GRID_BINS = gbmr_pkg::GRID_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [gbmr_pkg::OP_W-1:0]           opcode,
  input  logic [gbmr_pkg::IDX_W-1:0]          grid_index,
  input  logic signed [gbmr_pkg::VAL_W-1:0]   node_value,
  input  logic                                init_done,
  input  logic                                pop,
  output logic                                busy,
  output gbmr_pkg::head_t                     head
);

  localparam int QPTR_W = $clog2(gbmr_pkg::QUEUE_DEPTH);
  localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(gbmr_pkg::QUEUE_DEPTH);

  gbmr_pkg::cmd_t    entry [gbmr_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;

  gbmr_pkg::cmd_t    cmd_in;
  logic              in_range;
  logic              keep;
  logic              push;

  // Classify the item; out of range accumulates and unused opcodes are dropped here.
  always_comb begin
    in_range        = (32'(grid_index) < 32'(GRID_BINS));
    cmd_in.in_range = in_range;
    cmd_in.index    = grid_index;
    cmd_in.value    = node_value;
    cmd_in.kind     = gbmr_pkg::KIND_ACC;
    keep            = 1'b0;
    case (opcode)
      gbmr_pkg::OP_ACC: begin
        cmd_in.kind = gbmr_pkg::KIND_ACC;
        keep        = in_range;
      end
      gbmr_pkg::OP_RES: begin
        cmd_in.kind = gbmr_pkg::KIND_RES;
        keep        = 1'b1;
      end
      gbmr_pkg::OP_CLR: begin
        cmd_in.kind = gbmr_pkg::KIND_CLR;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = (fill == FULL_COUNT) || !init_done;
  assign push       = start && !busy && keep;
  assign head.valid = (fill != '0);
  assign head.cmd   = entry[rptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= cmd_in;
    end
  end

endmodule

FILE: rtl/gbmr_back.sv
// Back end: sequencer over the bin store that accumulates, divides, clears and returns results.
module gbmr_back #(
  parameter int GRID_BINS  = gbmr_pkg::GRID_BINS_DEF,
  parameter int COUNT_BITS = gbmr_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gbmr_pkg::head_t                    head,
  output logic                               pop,
  output logic                               init_done,
  output logic                               done,
  output logic signed [gbmr_pkg::VAL_W-1:0]  residual,
  output logic signed [gbmr_pkg::VAL_W-1:0]  bin_mean,
  output logic                               status
);

  localparam int SUM_W  = gbmr_pkg::SUM_W;
  localparam int VAL_W  = gbmr_pkg::VAL_W;
  localparam int IDX_W  = gbmr_pkg::IDX_W;
  localparam int ADDR_W = $clog2(GRID_BINS);
  localparam int RAM_W  = SUM_W + COUNT_BITS;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_BINS - 1);

  gbmr_pkg::back_state_t state;
  gbmr_pkg::back_state_t state_next;

  logic [ADDR_W-1:0]        clr_addr;
  logic [ADDR_W-1:0]        cur_addr;
  logic signed [VAL_W-1:0]  cur_val;
  logic                     neg;
  logic                     empty;
  logic signed [VAL_W-1:0]  mean;

  logic [ADDR_W+IDX_W-1:0]  head_addr_wide;
  logic [ADDR_W-1:0]        head_addr;

  logic                     rd_en;
  logic [RAM_W-1:0]         rd_data;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [RAM_W-1:0]         wr_data;

  logic signed [SUM_W-1:0]  rd_sum;
  logic [COUNT_BITS-1:0]    rd_cnt;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic [SUM_W:0]           acc_sum;
  logic signed [SUM_W-1:0]  acc_sat;
  logic [SUM_W-1:0]         sum_mag;

  logic                     div_start;
  logic                     div_done;
  logic [SUM_W-1:0]         div_quo;
  logic [VAL_W-1:0]         quo_lo;
  logic                     pos_ovf;
  logic                     neg_ovf;
  logic signed [VAL_W-1:0]  mean_sat;

  logic [VAL_W:0]           diff;
  logic signed [VAL_W-1:0]  res_sat;

  // Bin store: count above sum in one word.
  gbmr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (GRID_BINS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head_addr),
    .rd_data (rd_data)
  );

  // Divider for the bin mean.
  gbmr_div #(
    .DVD_W (SUM_W),
    .DIV_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (rd_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Address of the queued command.
  assign head_addr_wide = (ADDR_W + IDX_W)'(head.cmd.index);
  assign head_addr      = head_addr_wide[ADDR_W-1:0];

  // Accumulate path: saturating add and count increment.
  always_comb begin
    rd_sum  = rd_data[SUM_W-1:0];
    rd_cnt  = rd_data[RAM_W-1:SUM_W];
    cnt_inc = rd_cnt + 1'b1;
    acc_sum = {rd_sum[SUM_W-1], rd_sum}
            + {{(SUM_W + 1 - VAL_W){cur_val[VAL_W-1]}}, cur_val};
    if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
      acc_sat = acc_sum[SUM_W] ? gbmr_pkg::SUM_MIN : gbmr_pkg::SUM_MAX;
    end else begin
      acc_sat = acc_sum[SUM_W-1:0];
    end
    sum_mag = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;
  end

  // Signed, saturated mean from the quotient magnitude.
  always_comb begin
    quo_lo  = div_quo[VAL_W-1:0];
    pos_ovf = |div_quo[SUM_W-1:VAL_W-1];
    neg_ovf = (|div_quo[SUM_W-1:VAL_W]) || (div_quo[VAL_W-1] && (|div_quo[VAL_W-2:0]));
    if (neg) begin
      mean_sat = neg_ovf ? gbmr_pkg::WORD_MIN : (VAL_W'(0) - quo_lo);
    end else begin
      mean_sat = pos_ovf ? gbmr_pkg::WORD_MAX : quo_lo;
    end
  end

  // Residual, saturated to one word.
  always_comb begin
    diff = {cur_val[VAL_W-1], cur_val} - {mean[VAL_W-1], mean};
    if (diff[VAL_W] != diff[VAL_W-1]) begin
      res_sat = diff[VAL_W] ? gbmr_pkg::WORD_MIN : gbmr_pkg::WORD_MAX;
    end else begin
      res_sat = diff[VAL_W-1:0];
    end
  end

  // Next state and store control.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = clr_addr;
    wr_data    = '0;
    div_start  = 1'b0;
    case (state)
      gbmr_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = gbmr_pkg::ST_IDLE;
        end
      end
      gbmr_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.kind)
            gbmr_pkg::KIND_ACC: begin
              rd_en      = 1'b1;
              state_next = gbmr_pkg::ST_ACC;
            end
            gbmr_pkg::KIND_RES: begin
              rd_en      = head.cmd.in_range;
              state_next = head.cmd.in_range ? gbmr_pkg::ST_RES_RD : gbmr_pkg::ST_RES_OUT;
            end
            gbmr_pkg::KIND_CLR: begin
              state_next = gbmr_pkg::ST_CLEAR;
            end
            default: begin
              state_next = gbmr_pkg::ST_IDLE;
            end
          endcase
        end
      end
      gbmr_pkg::ST_ACC: begin
        // A full count drops the accumulate.
        wr_en      = ~&rd_cnt;
        wr_addr    = cur_addr;
        wr_data    = {cnt_inc, acc_sat};
        state_next = gbmr_pkg::ST_IDLE;
      end
      gbmr_pkg::ST_RES_RD: begin
        if (rd_cnt == '0) begin
          state_next = gbmr_pkg::ST_RES_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = gbmr_pkg::ST_RES_DIV;
        end
      end
      gbmr_pkg::ST_RES_DIV: begin
        if (div_done) begin
          state_next = gbmr_pkg::ST_RES_OUT;
        end
      end
      gbmr_pkg::ST_RES_OUT: begin
        state_next = gbmr_pkg::ST_IDLE;
      end
      default: begin
        state_next = gbmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts a clearing pass over the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbmr_pkg::ST_CLEAR;
      clr_addr  <= '0;
      init_done <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == gbmr_pkg::ST_RES_OUT);
      if (state == gbmr_pkg::ST_CLEAR) begin
        if (clr_addr == LAST_ADDR) begin
          clr_addr  <= '0;
          init_done <= 1'b1;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  // Working registers and result registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_addr <= head_addr;
      cur_val  <= head.cmd.value;
      empty    <= 1'b1;
      mean     <= '0;
    end
    if (state == gbmr_pkg::ST_RES_RD) begin
      neg   <= rd_sum[SUM_W-1];
      empty <= (rd_cnt == '0);
    end
    if ((state == gbmr_pkg::ST_RES_DIV) && div_done) begin
      mean <= mean_sat;
    end
    if (state == gbmr_pkg::ST_RES_OUT) begin
      residual <= res_sat;
      bin_mean <= mean;
      status   <= empty;
    end
  end

endmodule

FILE: rtl/grid_bin_mean_residual.sv
// Top level of the grid bin mean and residual block: front end, command queue and back end.
//
//   channel   direction  handshake        payload
//   command   in         start / busy     opcode, grid_index, node_value
//   result    out        done (strobe)    residual, bin_mean, status
//
// An accumulate reads the bin and writes it back in the back end; a residual of a populated
// bin waits on the divider, which retires two quotient bits per cycle over the 48-bit bin sum.
// A clear walks the bin store one bin per cycle.
// After reset the same clearing pass runs with busy held high.
// Busy is high while the two-entry command queue is full; each result is shown for one
// cycle on done and the receiver cannot stall it.
module grid_bin_mean_residual #(
  parameter int GRID_BINS  = gbmr_pkg::GRID_BINS_DEF,
  parameter int COUNT_BITS = gbmr_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [gbmr_pkg::OP_W-1:0]          opcode,
  input  logic [gbmr_pkg::IDX_W-1:0]         grid_index,
  input  logic signed [gbmr_pkg::VAL_W-1:0]  node_value,
  output logic                               done,
  output logic signed [gbmr_pkg::VAL_W-1:0]  residual,
  output logic signed [gbmr_pkg::VAL_W-1:0]  bin_mean,
  output logic                               status
);

  gbmr_pkg::head_t head;
  logic            pop;
  logic            init_done;

  // Accept and classify, then queue.
  gbmr_front #(
    .GRID_BINS (GRID_BINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .grid_index (grid_index),
    .node_value (node_value),
    .init_done  (init_done),
    .pop        (pop),
    .busy       (busy),
    .head       (head)
  );

  // Carry out queued work on the bin store.
  gbmr_back #(
    .GRID_BINS  (GRID_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .init_done (init_done),
    .done      (done),
    .residual  (residual),
    .bin_mean  (bin_mean),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // No result may appear before the store has been cleared after reset.
  a_no_result_before_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !done)
    else $error("result strobe before the clearing pass finished");

  // An empty bin always reports a zero mean.
  a_empty_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (bin_mean == '0))
    else $error("empty bin reported a nonzero mean");

  // A result strobe is never followed at once by another.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // The queue never pops while the pass after reset is still running.
  a_no_pop_before_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !pop)
    else $error("command taken before the clearing pass finished");
`endif

endmodule

FILE: tb/gbmr_mean_checker.sv
// Checker that predicts the bin mean and residual answers of the block and compares them.
`timescale 1ns / 1ps
module gbmr_mean_checker #(
  parameter int GRID_BINS  = gbmr_pkg::GRID_BINS_DEF,
  parameter int COUNT_BITS = gbmr_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [gbmr_pkg::OP_W-1:0]          opcode,
  input  logic [gbmr_pkg::IDX_W-1:0]         grid_index,
  input  logic signed [gbmr_pkg::VAL_W-1:0]  node_value,
  input  logic                               done,
  input  logic signed [gbmr_pkg::VAL_W-1:0]  residual,
  input  logic signed [gbmr_pkg::VAL_W-1:0]  bin_mean,
  input  logic                               status,
  output int                                 fail_count,
  output int                                 pending
);
  import gbmr_pkg::*;

  // One answer of a residual command: the residual, the bin mean and the empty flag.
  typedef struct packed {
    logic signed [VAL_W-1:0] resid;
    logic signed [VAL_W-1:0] mean;
    logic                    empty;
  } bin_answer_t;

  // Predicted copy of the bin store.
  logic signed [SUM_W-1:0] bin_sums   [GRID_BINS];
  logic [COUNT_BITS-1:0]   bin_counts [GRID_BINS];

  // Answers owed by the block, oldest first.
  bin_answer_t answers_due [$];
  int          mismatches = 0;

  // Empty every bin, as reset and the clear command do.
  function automatic void clear_bins();
    for (int i = 0; i < GRID_BINS; i++) begin
      bin_sums[i]   = '0;
      bin_counts[i] = '0;
    end
  endfunction

  // Saturate a wide value to the signed 32-bit word range.
  function automatic logic signed [VAL_W-1:0] clamp_word(input longint x);
    if (x > longint'(WORD_MAX)) return WORD_MAX;
    if (x < longint'(WORD_MIN)) return WORD_MIN;
    return x[VAL_W-1:0];
  endfunction

  // Count a failure and report only the first ten of them.
  task automatic log_fault(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", what);
    end
  endtask

  always @(posedge clk) begin : watch
    longint      sum_next;
    longint      mean_wide;
    logic        in_range;
    bin_answer_t answer;
    bin_answer_t due;
    if (rst) begin
      clear_bins();
      answers_due.delete();
    end else begin
      // A result transfer is matched against the oldest answer owed.
      if (done) begin
        if (answers_due.size() == 0) begin
          log_fault($sformatf("unexpected result at %0t: residual %0d mean %0d status %0b",
                              $time, residual, bin_mean, status));
        end else begin
          due = answers_due.pop_front();
          if (residual !== due.resid || bin_mean !== due.mean || status !== due.empty) begin
            log_fault($sformatf({"mismatch at %0t: expected residual %0d mean %0d status %0b,",
                                 " got residual %0d mean %0d status %0b"}, $time,
                                due.resid, due.mean, due.empty, residual, bin_mean, status));
          end
        end
      end

      // A command transfer updates the predicted store or owes an answer.
      if (start && !busy) begin
        in_range = int'(grid_index) < GRID_BINS;
        case (opcode)
          OP_ACC: begin
            // A bin at its full count drops the node; the sum saturates at 48 bits.
            if (in_range && bin_counts[grid_index] != '1) begin
              sum_next = longint'(bin_sums[grid_index]) + longint'(node_value);
              if (sum_next > longint'(SUM_MAX)) begin
                sum_next = SUM_MAX;
              end else if (sum_next < longint'(SUM_MIN)) begin
                sum_next = SUM_MIN;
              end
              bin_sums[grid_index]   = sum_next[SUM_W-1:0];
              bin_counts[grid_index] = bin_counts[grid_index] + 1'b1;
            end
          end
          OP_RES: begin
            // An empty bin answers with a zero mean and the empty flag.
            mean_wide    = 0;
            answer.empty = 1'b1;
            if (in_range && bin_counts[grid_index] != '0) begin
              mean_wide    = longint'(bin_sums[grid_index]) / longint'(bin_counts[grid_index]);
              answer.empty = 1'b0;
            end
            answer.mean  = clamp_word(mean_wide);
            answer.resid = clamp_word(longint'(node_value) - longint'(answer.mean));
            answers_due.push_back(answer);
          end
          OP_CLR: begin
            clear_bins();
          end
          default: begin
            // The unused opcode leaves everything as it is.
          end
        endcase
      end
    end
    pending    <= answers_due.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/tb_grid_bin_mean_residual.sv
// Testbench top for the grid bin mean and residual block: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb_grid_bin_mean_residual;
  import gbmr_pkg::*;

  // The opcode that the block leaves unused.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A correct run spends most of its time in the clear walks over the bin store and the
  // residual divisions.
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [OP_W-1:0]          opcode = OP_ACC;
  logic [IDX_W-1:0]         grid_index = '0;
  logic signed [VAL_W-1:0]  node_value = '0;
  logic                     busy;
  logic                     done;
  logic signed [VAL_W-1:0]  residual;
  logic signed [VAL_W-1:0]  bin_mean;
  logic                     status;
  int                       fail_count;
  int                       pending;
  int                       cycles = 0;
  int                       idle_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  grid_bin_mean_residual dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .grid_index (grid_index),
    .node_value (node_value),
    .done       (done),
    .residual   (residual),
    .bin_mean   (bin_mean),
    .status     (status)
  );

  gbmr_mean_checker mean_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .grid_index (grid_index),
    .node_value (node_value),
    .done       (done),
    .residual   (residual),
    .bin_mean   (bin_mean),
    .status     (status),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** grid_bin_mean_residual: FAILED **");
      $finish;
    end
  end

  // Present one command and hold it until the block takes the transfer, then maybe idle.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
    start      <= 1'b1;
    opcode     <= op;
    grid_index <= idx;
    node_value <= val;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      // Junk on the fields while start is low must be ignored.
      start      <= 1'b0;
      opcode     <= OP_W'($urandom);
      grid_index <= IDX_W'($urandom);
      node_value <= VAL_W'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // Stop sending until every answer owed has come back.
  task automatic wait_for_answers();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Node values leaning toward the extremes and toward small Q16.16 numbers.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(4))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return VAL_W'((int'($urandom_range(2047)) - 1024) * 65536);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Bin indexes, with the edges of the grid picked often.
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return IDX_W'($urandom);
    endcase
  endfunction

  // Surveys: optionally clear, accumulate nodes into a few bins, then ask for their residuals.
  // A little noise is mixed in: the unused opcode and residuals of arbitrary bins.
  task automatic run_surveys(input int target);
    int                       sent;
    int                       pool_size;
    int                       pick;
    logic [IDX_W-1:0]         pool [8];
    logic [IDX_W-1:0]         node_bins [$];
    logic signed [VAL_W-1:0]  node_vals [$];
    logic [IDX_W-1:0]         idx;
    logic signed [VAL_W-1:0]  val;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(1) == 0) begin
        send_command(OP_CLR, IDX_W'($urandom), VAL_W'($urandom));
        sent++;
      end
      pool_size = $urandom_range(8, 1);
      foreach (pool[i]) pool[i] = pick_index();

      // Accumulate phase.
      repeat ($urandom_range(40, 4)) begin
        case ($urandom_range(19))
          0: send_command(OP_UNUSED, IDX_W'($urandom), VAL_W'($urandom));
          1: begin
            send_command(OP_RES, pick_index(), pick_value());
            sent++;
          end
          default: begin
            idx = pool[$urandom_range(pool_size - 1)];
            val = pick_value();
            send_command(OP_ACC, idx, val);
            node_bins.push_back(idx);
            node_vals.push_back(val);
            sent++;
          end
        endcase
      end

      // Residual phase, nodes taken in random order.
      while (node_bins.size() != 0) begin
        pick = $urandom_range(node_bins.size() - 1);
        val  = ($urandom_range(3) == 0) ? pick_value() : node_vals[pick];
        send_command(OP_RES, node_bins[pick], val);
        node_bins.delete(pick);
        node_vals.delete(pick);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with light sender idling.
    idle_pct = 12;
    // Empty bins at both ends of the grid.
    send_command(OP_RES, 12'h000, 32'sd0);
    send_command(OP_RES, 12'hFFF, WORD_MIN);
    // Largest mean against the most negative node: the residual saturates low.
    send_command(OP_ACC, 12'h000, WORD_MAX);
    send_command(OP_ACC, 12'h000, WORD_MAX);
    send_command(OP_RES, 12'h000, WORD_MIN);
    // Large negative mean against the largest node: the residual saturates high.
    send_command(OP_ACC, 12'hFFF, WORD_MIN);
    send_command(OP_ACC, 12'hFFF, WORD_MIN);
    send_command(OP_ACC, 12'hFFF, 32'sd1);
    send_command(OP_RES, 12'hFFF, WORD_MAX);
    // Division truncates toward zero for both signs.
    send_command(OP_ACC, 12'd5, 32'sd7);
    send_command(OP_ACC, 12'd5, -32'sd2);
    send_command(OP_RES, 12'd5, 32'sd0);
    send_command(OP_ACC, 12'd5, -32'sd10);
    send_command(OP_RES, 12'd5, 32'sd0);
    // The unused opcode changes nothing.
    send_command(OP_UNUSED, 12'd5, WORD_MAX);
    send_command(OP_RES, 12'd5, 32'sh0001_0000);
    // Alternating bit patterns.
    send_command(OP_ACC, 12'hAAA, 32'sh5555_5555);
    send_command(OP_RES, 12'h555, 32'shAAAA_AAAA);
    send_command(OP_RES, 12'hAAA, 32'sh5555_5555);
    // A clear empties every bin.
    send_command(OP_CLR, 12'h000, 32'sd0);
    send_command(OP_RES, 12'h000, 32'sd0);
    send_command(OP_RES, 12'd5, 32'sd0);

    // Random surveys: sparse idling, a full pause, heavy idling, then none.
    run_surveys(270);
    wait_for_answers();
    idle_pct = 84;
    run_surveys(270);
    idle_pct = 0;
    run_surveys(270);

    // Drain, then allow for a trailing clear walk before the verdict.
    wait_for_answers();
    repeat (GRID_BINS_DEF + 64) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** grid_bin_mean_residual: PASSED **");
    end else begin
      $display("** grid_bin_mean_residual: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gbmr_pkg.sv
rtl/gbmr_ram.sv
rtl/gbmr_div.sv
rtl/gbmr_front.sv
rtl/gbmr_back.sv
rtl/grid_bin_mean_residual.sv
tb/gbmr_mean_checker.sv
tb/tb_grid_bin_mean_residual.sv
